// ===== hw/rtl/lbcm_pkg.sv =====
// Shared constants, types and state codes for the line break coordinate map.
package lbcm_pkg;

  localparam int MAX_BREAKS = 64;
  localparam int IDX_W      = $clog2(MAX_BREAKS);
  localparam int CNT_W      = $clog2(MAX_BREAKS + 1);

  localparam int LINE_W  = 24;
  localparam int CUR_W   = 23;
  localparam int FILE_W  = 8;
  localparam int MLINE_W = 25;

  // One break of the table.
  typedef struct packed {
    logic [CUR_W-1:0]          start;
    logic signed [MLINE_W-1:0] offset;
    logic [FILE_W-1:0]         file;
  } entry_t;

  // Write command from the sequencer to the table.
  typedef struct packed {
    logic             en;
    logic             append;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ADD,
    ST_DONE
  } state_t;

  localparam logic MODE_MAP = 1'b0;
  localparam logic MODE_ADD = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// ===== hw/rtl/lbcm_if.sv =====
// Request and result channel interfaces of the line break coordinate map.
interface lbcm_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic signed [23:0] line;
  logic [22:0] current_line;
  logic [7:0]  file_id;

  modport source (output valid, mode, line, current_line, file_id, input ready);
  modport sink   (input valid, mode, line, current_line, file_id, output ready);
endinterface

interface lbcm_out_if;
  logic        valid;
  logic        ready;
  logic signed [24:0] mapped_line;
  logic [7:0]  mapped_file;
  logic        no_file;
  logic        status;

  modport source (output valid, mapped_line, mapped_file, no_file, status, input ready);
  modport sink   (input valid, mapped_line, mapped_file, no_file, status, output ready);
endinterface

// ===== hw/rtl/lbcm_table.sv =====
// Break table storage: entry memory, the first entry's registers and the fill count.
module lbcm_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lbcm_pkg::FILE_W-1:0]       cfg_wr_data,
  input  logic [lbcm_pkg::IDX_W-1:0]        rd_addr,
  input  lbcm_pkg::tbl_wr_t                 wr,
  output lbcm_pkg::entry_t                  rd_entry,
  output logic [lbcm_pkg::CNT_W-1:0]        count
);
  import lbcm_pkg::*;

  entry_t                    mem [MAX_BREAKS];
  entry_t                    mem_q;
  logic                      rd_is0;
  logic signed [MLINE_W-1:0] e0_offset;
  logic [FILE_W-1:0]         e0_file;
  logic                      add_seen;

  // Entry 0 lives in registers since its reset value is defined; the memory
  // only ever holds entries below the fill count.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx != '0)) begin
      mem[wr.idx] <= wr.data;
    end
    mem_q  <= mem[rd_addr];
    rd_is0 <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_offset <= '0;
      e0_file   <= '0;
      add_seen  <= 1'b0;
      count     <= CNT_W'(1);
    end else begin
      if (wr.en) begin
        add_seen <= 1'b1;
        if (wr.append) begin
          count <= count + CNT_W'(1);
        end
        if (wr.idx == '0) begin
          e0_offset <= wr.data.offset;
          e0_file   <= wr.data.file;
        end
      end else if (cfg_wr_en && !add_seen) begin
        e0_file <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    if (rd_is0) begin
      rd_entry.start  = CUR_W'(1);
      rd_entry.offset = e0_offset;
      rd_entry.file   = e0_file;
    end else begin
      rd_entry = mem_q;
    end
  end

endmodule

// ===== hw/rtl/lbcm_ctrl.sv =====
// Sequencer with the shared subtract unit, walk counter and result register.
module lbcm_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  lbcm_in_if.sink                           in_ch,
  lbcm_out_if.source                        out_ch,
  input  logic [lbcm_pkg::CNT_W-1:0]        count,
  input  lbcm_pkg::entry_t                  rd_entry,
  output logic [lbcm_pkg::IDX_W-1:0]        rd_addr,
  output lbcm_pkg::tbl_wr_t                 wr
);
  import lbcm_pkg::*;

  state_t                    state, state_next;
  logic [IDX_W-1:0]          walk_idx;
  logic [IDX_W-1:0]          newest;
  logic signed [LINE_W-1:0]  req_line;
  logic [CUR_W-1:0]          req_cur;
  logic [FILE_W-1:0]         req_fid;

  logic signed [MLINE_W-1:0] res_line;
  logic [FILE_W-1:0]         res_file;
  logic                      res_nofile;
  logic                      res_status;

  logic signed [MLINE_W-1:0] out_line;
  logic [FILE_W-1:0]         out_file;
  logic                      out_nofile;
  logic                      out_status;
  logic                      out_valid;

  logic signed [MLINE_W-1:0] sub_a, sub_b, sub_y;
  logic signed [MLINE_W-1:0] line_ext;
  logic                      accept, nonpos, walk_more;
  logic                      res_load, out_load;
  logic signed [MLINE_W-1:0] res_line_next;
  logic [FILE_W-1:0]         res_file_next;
  logic                      res_nofile_next, res_status_next;

  assign newest   = IDX_W'(count - CNT_W'(1));
  assign line_ext = MLINE_W'(req_line);
  assign nonpos   = in_ch.line[LINE_W-1] || (in_ch.line == '0);
  // The walk moves on while the entry starts beyond the line; entry 0 starts at 1.
  assign walk_more = ({1'b0, rd_entry.start} > $unsigned(req_line));

  // Shared subtractor: mapped line in a walk, new offset in an add.
  always_comb begin
    if (state == ST_ADD) begin
      sub_a = MLINE_W'({2'b00, req_cur});
      sub_b = line_ext;
    end else begin
      sub_a = line_ext;
      sub_b = rd_entry.offset;
    end
  end
  assign sub_y = sub_a - sub_b;

  always_comb begin
    state_next      = state;
    in_ch.ready     = (state == ST_IDLE);
    accept          = in_ch.valid && (state == ST_IDLE);
    rd_addr         = (state == ST_WALK) ? (walk_idx - IDX_W'(1)) : newest;
    wr              = '0;
    res_load        = 1'b0;
    res_line_next   = '0;
    res_file_next   = '0;
    res_nofile_next = 1'b0;
    res_status_next = STATUS_OK;
    out_load        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode == MODE_ADD) begin
            state_next = ST_ADD;
          end else if (nonpos) begin
            res_load        = 1'b1;
            res_line_next   = MLINE_W'(in_ch.line);
            res_nofile_next = 1'b1;
            state_next      = ST_DONE;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!walk_more) begin
          res_load      = 1'b1;
          res_line_next = sub_y;
          res_file_next = rd_entry.file;
          state_next    = ST_DONE;
        end
      end
      ST_ADD: begin
        res_load        = 1'b1;
        wr.data.start   = req_cur;
        wr.data.offset  = sub_y;
        wr.data.file    = req_fid;
        if (rd_entry.start == req_cur) begin
          wr.en  = 1'b1;
          wr.idx = newest;
        end else if (count == CNT_W'(MAX_BREAKS)) begin
          res_status_next = STATUS_FULL;
        end else begin
          wr.en     = 1'b1;
          wr.append = 1'b1;
          wr.idx    = IDX_W'(count);
        end
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_line <= in_ch.line;
      req_cur  <= in_ch.current_line;
      req_fid  <= in_ch.file_id;
      walk_idx <= newest;
    end else if ((state == ST_WALK) && walk_more) begin
      walk_idx <= walk_idx - IDX_W'(1);
    end
    if (res_load) begin
      res_line   <= res_line_next;
      res_file   <= res_file_next;
      res_nofile <= res_nofile_next;
      res_status <= res_status_next;
    end
    if (out_load) begin
      out_line   <= res_line;
      out_file   <= res_file;
      out_nofile <= res_nofile;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.mapped_line = out_line;
  assign out_ch.mapped_file = out_file;
  assign out_ch.no_file     = out_nofile;
  assign out_ch.status      = out_status;

endmodule

// ===== hw/rtl/line_break_coordinate_map_top.sv =====
// Top level of the line break coordinate map: table storage plus sequencer.
//
// The block keeps a table of line breaks and answers one result per request.
// A request on in_ch either maps a cumulative line (mode 0) to a line within
// its file plus a file id, or adds a break (mode 1). Results leave on out_ch.
// Both channels use valid/ready; a request moves at an edge where both are high.
// The cfg_wr_en/cfg_wr_data port writes the start file id, which also sets the
// file id of the first break until the first add has been taken.
//
// Requests are handled one at a time. A map walks back from the newest break,
// one table entry per cycle through the single read port of the break memory,
// skipping each break that starts beyond the line (at most 63), and then loads
// the result register. A nonpositive line loads the result register at once; an
// add reads the newest break, then writes the table and the result register.
// The next request is taken once the result has moved to the output register.
// in_ch.ready is high only while the sequencer is idle.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; if the receiver stalls, the next result is held
// inside the sequencer until the output register frees up.
// Reset leaves one break (start 1, offset 0, file id 0) and no result pending.
module line_break_coordinate_map_top (
  input  logic                        clk,
  input  logic                        rst,
  lbcm_in_if.sink                     in_ch,
  lbcm_out_if.source                  out_ch,
  input  logic                        cfg_wr_en,
  input  logic [lbcm_pkg::FILE_W-1:0] cfg_wr_data
);
  import lbcm_pkg::*;

  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] count;
  entry_t           rd_entry;
  tbl_wr_t          wr;

  // Break storage; the read data always belongs to the address of the prior cycle.
  lbcm_table u_table (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rd_addr     (rd_addr),
    .wr          (wr),
    .rd_entry    (rd_entry),
    .count       (count)
  );

  // Sequencer that walks the table and owns the output register.
  lbcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .count    (count),
    .rd_entry (rd_entry),
    .rd_addr  (rd_addr),
    .wr       (wr)
  );

endmodule

// ===== hw/rtl/lbcm_checker.sv =====
// Port-level checks for the line break coordinate map, bound to the top level.
module lbcm_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [24:0] mapped_line,
  input logic [7:0]        mapped_file,
  input logic              no_file,
  input logic              status
);

  // A pending result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // One request at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // A nonpositive map carries no file and never a full status.
  a_nofile: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_file |-> (mapped_file == 8'd0) && !status)
    else $error("no_file result with file or status");

  // A dropped add reports nothing but its status.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> (mapped_line == 25'sd0) && !no_file && (mapped_file == 8'd0))
    else $error("full status with map fields set");

  // Reset clears any pending result.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind line_break_coordinate_map_top lbcm_checker u_lbcm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .mapped_line (out_ch.mapped_line),
  .mapped_file (out_ch.mapped_file),
  .no_file     (out_ch.no_file),
  .status      (out_ch.status)
);

// ===== dv/line_break_coordinate_map_top_test.sv =====
// Self-checking testbench for the line break coordinate map top level.
`timescale 1ns / 1ps

module line_break_coordinate_map_top_test;
  import lbcm_pkg::*;

  localparam int LINE_MAX    = 2 ** (LINE_W - 1) - 1;
  localparam int LINE_MIN    = -(2 ** (LINE_W - 1));
  localparam int CYCLE_LIMIT = 400000;
  // The receiver stops taking results for a long stretch once this many have arrived.
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 300;
  // Allow some slack after the last result; it outlasts the longest map walk.
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_REQS = 450;

  // What the stimulus queue asks of the driver.
  typedef enum logic [1:0] {
    ACT_REQUEST,
    ACT_CONFIG,
    ACT_DRAIN
  } stim_act_e;

  // One entry of the stimulus queue. For a configuration write the new start
  // file id travels in fid.
  typedef struct {
    stim_act_e                act;
    logic                     mode;
    logic signed [LINE_W-1:0] line;
    logic [CUR_W-1:0]         cur;
    logic [FILE_W-1:0]        fid;
    int                       gap;
  } stim_t;

  // One result as the block should present it.
  typedef struct {
    logic signed [MLINE_W-1:0] mapped_line;
    logic [FILE_W-1:0]         mapped_file;
    logic                      no_file;
    logic                      status;
  } line_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [FILE_W-1:0] cfg_wr_data;

  lbcm_in_if  req_ch ();
  lbcm_out_if res_ch ();

  line_break_coordinate_map_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (req_ch),
    .out_ch      (res_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the break table, kept in step with every accepted request
  // and every configuration write.
  logic [CUR_W-1:0]          brk_start  [MAX_BREAKS];
  logic signed [MLINE_W-1:0] brk_offset [MAX_BREAKS];
  logic [FILE_W-1:0]         brk_file   [MAX_BREAKS];
  int                        brk_used;
  bit                        adds_taken;
  logic [FILE_W-1:0]         start_fid;

  stim_t        pending [$];
  line_result_t expected_results [$];

  // Starts of the breaks the generator expects the table to hold, newest last.
  // The generator uses them to aim map requests at break boundaries and to
  // decide whether an add rewrites the newest break or appends.
  logic [CUR_W-1:0] gen_starts [$];

  int requests_offered = 0;
  int requests_taken   = 0;
  int results_taken    = 0;
  int results_noted    = 0;
  int mismatches       = 0;
  int cycle_count      = 0;
  int gap_left         = 0;
  int offered_gap      = 0;
  int stall_left       = 0;
  int hold_left        = 0;

  function automatic void clear_table();
    start_fid     = '0;
    brk_used      = 1;
    adds_taken    = 1'b0;
    brk_start[0]  = CUR_W'(1);
    brk_offset[0] = '0;
    brk_file[0]   = start_fid;
  endfunction

  // Computes the result of one request and applies an add to the shadow table.
  function automatic line_result_t resolve_request(logic mode, logic signed [LINE_W-1:0] line,
                                                   logic [CUR_W-1:0] cur,
                                                   logic [FILE_W-1:0] fid);
    line_result_t r;
    int ln;
    int e;
    int newest;
    r = '{mapped_line: '0, mapped_file: '0, no_file: 1'b0, status: STATUS_OK};
    ln = line;
    newest = brk_used - 1;
    if (mode == MODE_MAP) begin
      if (ln <= 0) begin
        r.mapped_line = MLINE_W'(ln);
        r.no_file     = 1'b1;
      end else begin
        // Walk back from the newest break to the first one that starts at or
        // before the line; the first break always starts at 1.
        e = newest;
        while (e > 0 && int'(brk_start[e]) > ln) e--;
        r.mapped_line = MLINE_W'(ln - int'(brk_offset[e]));
        r.mapped_file = brk_file[e];
      end
    end else if (brk_start[newest] == cur) begin
      brk_file[newest]   = fid;
      brk_offset[newest] = MLINE_W'(int'(cur) - ln);
      adds_taken         = 1'b1;
    end else if (brk_used >= MAX_BREAKS) begin
      r.status = STATUS_FULL;
    end else begin
      brk_start[brk_used]  = cur;
      brk_offset[brk_used] = MLINE_W'(int'(cur) - ln);
      brk_file[brk_used]   = fid;
      brk_used++;
      adds_taken = 1'b1;
    end
    return r;
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void queue_map(logic signed [LINE_W-1:0] ln, int gap);
    pending.push_back('{act: ACT_REQUEST, mode: MODE_MAP, line: ln, cur: '0, fid: '0, gap: gap});
  endfunction

  function automatic void queue_add(logic [CUR_W-1:0] cur, logic signed [LINE_W-1:0] ln,
                                    logic [FILE_W-1:0] fid, int gap);
    pending.push_back('{act: ACT_REQUEST, mode: MODE_ADD, line: ln, cur: cur, fid: fid,
                        gap: gap});
    if (gen_starts[gen_starts.size() - 1] != cur && gen_starts.size() < MAX_BREAKS)
      gen_starts.push_back(cur);
  endfunction

  // A configuration write goes out only once every outstanding result is in.
  function automatic void queue_config(logic [FILE_W-1:0] value);
    pending.push_back('{act: ACT_CONFIG, mode: MODE_MAP, line: '0, cur: '0, fid: value, gap: 0});
  endfunction

  function automatic void queue_drain();
    pending.push_back('{act: ACT_DRAIN, mode: MODE_MAP, line: '0, cur: '0, fid: '0, gap: 0});
  endfunction

  // Cycle counter, prediction at acceptance and result checking. Everything
  // is sampled at the rising edge; the testbench drives only at falling edges.
  always @(posedge clk) begin
    line_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** line_break_coordinate_map_top: FAILED **");
      $finish;
    end
    if (!rst) begin
      if (cfg_wr_en) begin
        start_fid = cfg_wr_data;
        // The first break follows the register only until an add is taken.
        if (!adds_taken) brk_file[0] = start_fid;
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(resolve_request(req_ch.mode, req_ch.line,
                                                   req_ch.current_line, req_ch.file_id));
        requests_taken++;
      end
      if (res_ch.valid && res_ch.ready) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: mapped_line %0d, mapped_file %0d",
                 res_ch.mapped_line, res_ch.mapped_file);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.mapped_line !== want.mapped_line) begin
            $error("mapped_line: expected %0d, got %0d", want.mapped_line, res_ch.mapped_line);
            mismatches++;
          end
          if (res_ch.mapped_file !== want.mapped_file) begin
            $error("mapped_file: expected %0d, got %0d", want.mapped_file, res_ch.mapped_file);
            mismatches++;
          end
          if (res_ch.no_file !== want.no_file) begin
            $error("no_file: expected %0b, got %0b", want.no_file, res_ch.no_file);
            mismatches++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, res_ch.status);
            mismatches++;
          end
        end
      end
    end
  end

  // Request driver. A request is finished once the acceptance counter has
  // caught up with the offer counter; the gap drawn for it delays the next one.
  // With a gap of zero valid simply stays high, so each signal sees a single
  // assignment per edge.
  always @(negedge clk) begin
    logic next_valid;
    logic next_cfg;
    next_valid = req_ch.valid;
    next_cfg   = 1'b0;
    if (!rst) begin
      if (req_ch.valid && requests_taken == requests_offered) begin
        next_valid = 1'b0;
        gap_left   = offered_gap;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          case (pending[0].act)
            ACT_REQUEST: begin
              req_ch.mode         <= pending[0].mode;
              req_ch.line         <= pending[0].line;
              req_ch.current_line <= pending[0].cur;
              req_ch.file_id      <= pending[0].fid;
              offered_gap = pending[0].gap;
              requests_offered++;
              next_valid = 1'b1;
              pending.delete(0);
            end
            ACT_CONFIG: begin
              // Every request yields a result, so an empty expectation queue
              // means the block is idle.
              if (expected_results.size() == 0) begin
                cfg_wr_data <= pending[0].fid;
                next_cfg = 1'b1;
                pending.delete(0);
              end
            end
            ACT_DRAIN: begin
              if (expected_results.size() == 0) pending.delete(0);
            end
            default: ;
          endcase
        end
      end
    end
    req_ch.valid <= next_valid;
    cfg_wr_en    <= next_cfg;
  end

  // Result receiver. It stalls a random number of cycles after each result,
  // runs without stalls in every third stretch of fifty results, and once
  // holds off long enough that the block backs up and stops taking requests.
  always @(negedge clk) begin
    logic next_ready;
    bit calm;
    next_ready = 1'b0;
    if (!rst) begin
      if (results_taken != results_noted) begin
        results_noted = results_taken;
        calm = ((results_taken / 50) % 3) == 1;
        stall_left = draw_gap(calm);
        if (results_taken == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else begin
        next_ready = 1'b1;
      end
    end
    res_ch.ready <= next_ready;
  end

  initial begin
    int i;
    int pick;
    int k;
    int ln;
    int nc;
    bit calm;
    bit full;

    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_MAP;
    req_ch.line         = '0;
    req_ch.current_line = '0;
    req_ch.file_id      = '0;
    res_ch.ready        = 1'b0;
    clear_table();
    gen_starts.push_back(1);

    // Directed part. The start file id is written before any add, so it
    // shows up on maps that land in the first break.
    queue_config(8'hFF);
    queue_map(1, draw_gap(0));
    queue_map(LINE_MAX, draw_gap(0));
    // Nonpositive lines come back unchanged with no file.
    queue_map(0, draw_gap(0));
    queue_map(LINE_MIN, draw_gap(0));
    queue_map(-1, draw_gap(0));
    queue_config(8'h00);
    queue_map(5, draw_gap(0));
    queue_config(8'h5A);
    queue_map(7, draw_gap(0));
    // An add at current line 1 rewrites the first break and freezes its file id, so
    // the late register write after it must not change the first break.
    queue_add(1, 1, 8'h33, draw_gap(0));
    queue_map(1, draw_gap(0));
    queue_config(8'hC3);
    queue_map(2, draw_gap(0));
    // Append a break, probe both sides of it, then rewrite it in place.
    queue_add(100, 1, 8'h07, draw_gap(0));
    queue_map(99, draw_gap(0));
    queue_map(100, draw_gap(0));
    queue_add(100, 50, 8'h09, draw_gap(0));
    queue_map(150, draw_gap(0));
    // Offsets at both ends of the range that an add can reach.
    queue_add(LINE_MAX, LINE_MIN, 8'hFF, draw_gap(0));
    queue_map(LINE_MAX, draw_gap(0));
    queue_add(0, LINE_MAX, 8'h00, draw_gap(0));
    queue_map(LINE_MAX, draw_gap(0));
    queue_map(LINE_MIN, draw_gap(0));
    queue_drain();

    // Random part. Adds are frequent until the table is full, then rarer;
    // they then mostly bounce off with a full status or rewrite the newest.
    for (i = 0; i < RANDOM_REQS; i++) begin
      calm = ((i / 40) % 3) == 2;
      full = gen_starts.size() >= MAX_BREAKS;
      if (i == 150) begin
        queue_config(FILE_W'($urandom));
      end else if (i == 225) begin
        queue_config(8'h00);
      end else if (i == 300) begin
        queue_drain();
        queue_config(8'hFF);
      end
      if ($urandom_range(0, 99) < (full ? 12 : 40)) begin
        if ($urandom_range(0, 3) == 0) begin
          nc = gen_starts[gen_starts.size() - 1];
        end else if ($urandom_range(0, 3) == 0) begin
          nc = $urandom_range(0, 2 ** CUR_W - 1);
        end else begin
          nc = (int'(gen_starts[gen_starts.size() - 1]) + $urandom_range(1, 100000))
               % (2 ** CUR_W);
        end
        if ($urandom_range(0, 3) == 0) ln = $urandom;
        else ln = $urandom_range(1, 5000);
        queue_add(CUR_W'(nc), LINE_W'(ln), FILE_W'($urandom), draw_gap(calm));
      end else begin
        pick = $urandom_range(0, 5);
        case (pick)
          0, 1: begin
            k  = $urandom_range(0, gen_starts.size() - 1);
            ln = int'(gen_starts[k]) + $urandom_range(0, 4) - 2;
            if (ln > LINE_MAX) ln = LINE_MAX;
          end
          2: ln = $urandom;
          3: ln = $urandom_range(1, 1000);
          4: ln = -int'($urandom_range(0, 100));
          default: begin
            case ($urandom_range(0, 3))
              0: ln = LINE_MAX;
              1: ln = LINE_MIN;
              2: ln = 0;
              default: ln = 1;
            endcase
          end
        endcase
        queue_map(LINE_W'(ln), draw_gap(calm));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for the queue to empty and every result to arrive, then give any
    // stray result time to show up before the verdict.
    while (pending.size() != 0 || req_ch.valid || requests_taken != requests_offered ||
           expected_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("** line_break_coordinate_map_top: PASSED **");
    end else begin
      $display("** line_break_coordinate_map_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lbcm_pkg.sv
hw/rtl/lbcm_if.sv
hw/rtl/lbcm_table.sv
hw/rtl/lbcm_ctrl.sv
hw/rtl/line_break_coordinate_map_top.sv
hw/rtl/lbcm_checker.sv
dv/line_break_coordinate_map_top_test.sv
